>>> hw/rtl/bclx_pkg.sv
// Shared types and constants for the brace config lexer checker.
package bclx_pkg;

	localparam int NEST_W = 5;

	// Character codes
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// Character roles
	localparam logic [2:0] ROLE_DROP    = 3'd0;
	localparam logic [2:0] ROLE_TEXT    = 3'd1;
	localparam logic [2:0] ROLE_OPEN    = 3'd2;
	localparam logic [2:0] ROLE_CLOSE   = 3'd3;
	localparam logic [2:0] ROLE_STMT    = 3'd4;
	localparam logic [2:0] ROLE_COMMENT = 3'd5;

	// Status codes
	localparam logic [1:0] ST_RUNNING = 2'd0;
	localparam logic [1:0] ST_ACCEPT  = 2'd1;
	localparam logic [1:0] ST_ERROR   = 2'd2;

	typedef enum logic [2:0] {
		MODE_WS      = 3'd0,
		MODE_WORD    = 3'd1,
		MODE_DQ      = 3'd2,
		MODE_DQ_ESC  = 3'd3,
		MODE_SQ      = 3'd4,
		MODE_SQ_ESC  = 3'd5,
		MODE_COMMENT = 3'd6,
		MODE_AFTERQ  = 3'd7
	} lex_mode_t;

	typedef enum logic [2:0] {
		KIND_START  = 3'd0,
		KIND_NORMAL = 3'd1,
		KIND_OPEN   = 3'd2,
		KIND_CLOSE  = 3'd3,
		KIND_END    = 3'd4
	} tok_kind_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       is_end;
	} text_item_t;

	typedef struct packed {
		logic [7:0]        byte_out;
		logic [2:0]        char_role;
		logic              word_start;
		logic              word_done;
		logic              new_statement;
		logic [NEST_W-1:0] nest_depth;
		logic [1:0]        status;
	} token_item_t;

	function automatic logic is_delim(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) ||
			(c == CH_SEMI) || (c == CH_LBRACE) || (c == CH_RBRACE);
	endfunction

endpackage

>>> hw/rtl/bclx_step.sv
// One lexer step: next state and result beat for one text item.
module bclx_step #(
	parameter int MAX_DEPTH = 16,
	parameter int DEPTH_W   = 5
) (
	input  bclx_pkg::text_item_t  item,
	input  bclx_pkg::lex_mode_t   mode,
	input  bclx_pkg::tok_kind_t   kind,
	input  logic [DEPTH_W-1:0]    depth,
	input  logic                  err,
	output bclx_pkg::lex_mode_t   nxt_mode,
	output bclx_pkg::tok_kind_t   nxt_kind,
	output logic [DEPTH_W-1:0]    nxt_depth,
	output logic                  nxt_err,
	output bclx_pkg::token_item_t res
);
	import bclx_pkg::*;

	localparam int EXT_W = (DEPTH_W > NEST_W) ? DEPTH_W : NEST_W;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);

	logic [7:0]       c;
	logic [2:0]       role;
	logic             ws;
	logic             wd;
	logic             ns;
	logic             do_between;
	logic             bad;
	logic [EXT_W-1:0] depth_ext;

	assign c = item.char_code;

	always_comb begin
		nxt_mode   = mode;
		nxt_kind   = kind;
		nxt_depth  = depth;
		nxt_err    = err;
		role       = ROLE_DROP;
		ws         = 1'b0;
		wd         = 1'b0;
		ns         = 1'b0;
		do_between = 1'b0;
		bad        = 1'b0;
		res        = '0;
		depth_ext  = EXT_W'(depth);

		if (item.is_end) begin
			bad = err || !(mode == MODE_WS || mode == MODE_COMMENT) ||
				!(kind == KIND_START || kind == KIND_END || kind == KIND_CLOSE) ||
				(depth != '0);
			res.nest_depth = depth_ext[NEST_W-1:0];
			res.status     = bad ? ST_ERROR : ST_ACCEPT;
			// rearm
			nxt_mode  = MODE_WS;
			nxt_kind  = KIND_START;
			nxt_depth = '0;
			nxt_err   = 1'b0;
		end else begin
			unique case (mode)
				MODE_WS: begin
					do_between = 1'b1;
				end
				MODE_WORD: begin
					if (is_delim(c)) begin
						wd         = 1'b1;
						nxt_mode   = MODE_WS;
						do_between = 1'b1;
					end else begin
						role = ROLE_TEXT;
					end
				end
				MODE_DQ, MODE_SQ: begin
					if (c == ((mode == MODE_DQ) ? CH_DQUOTE : CH_SQUOTE)) begin
						role     = ROLE_TEXT;
						nxt_mode = MODE_AFTERQ;
					end else if (c == CH_BSLASH) begin
						role     = ROLE_DROP;
						nxt_mode = (mode == MODE_DQ) ? MODE_DQ_ESC : MODE_SQ_ESC;
					end else begin
						role = ROLE_TEXT;
					end
				end
				MODE_DQ_ESC: begin
					role     = ROLE_TEXT;
					nxt_mode = MODE_DQ;
				end
				MODE_SQ_ESC: begin
					role     = ROLE_TEXT;
					nxt_mode = MODE_SQ;
				end
				MODE_COMMENT: begin
					if (c == CH_LF || c == CH_CR) begin
						role     = ROLE_DROP;
						nxt_mode = MODE_WS;
					end else begin
						role = ROLE_COMMENT;
					end
				end
				MODE_AFTERQ: begin
					wd = 1'b1;
					if (!is_delim(c)) nxt_err = 1'b1;
					nxt_mode   = MODE_WS;
					do_between = 1'b1;
				end
			endcase

			if (do_between) begin
				priority if (c == CH_LBRACE) begin
					role = ROLE_OPEN;
					if (kind != KIND_NORMAL) nxt_err = 1'b1;
					if (depth >= DEPTH_MAX) nxt_err = 1'b1;
					else nxt_depth = depth + 1'b1;
					nxt_kind = KIND_OPEN;
				end else if (c == CH_RBRACE) begin
					role = ROLE_CLOSE;
					if (!(kind == KIND_OPEN || kind == KIND_END || kind == KIND_CLOSE))
						nxt_err = 1'b1;
					if (depth == '0) nxt_err = 1'b1;
					else nxt_depth = depth - 1'b1;
					nxt_kind = KIND_CLOSE;
				end else if (c == CH_SEMI) begin
					role = ROLE_STMT;
					if (kind != KIND_NORMAL) nxt_err = 1'b1;
					nxt_kind = KIND_END;
				end else if (c == CH_HASH) begin
					role     = ROLE_COMMENT;
					nxt_mode = MODE_COMMENT;
				end else if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
					role = ROLE_DROP;
				end else begin
					role     = ROLE_TEXT;
					ws       = 1'b1;
					ns       = (kind != KIND_NORMAL);
					nxt_kind = KIND_NORMAL;
					nxt_mode = (c == CH_DQUOTE) ? MODE_DQ :
						(c == CH_SQUOTE) ? MODE_SQ : MODE_WORD;
				end
			end

			depth_ext         = EXT_W'(nxt_depth);
			res.byte_out      = c;
			res.char_role     = role;
			res.word_start    = ws;
			res.word_done     = wd;
			res.new_statement = ns;
			res.nest_depth    = depth_ext[NEST_W-1:0];
			res.status        = nxt_err ? ST_ERROR : ST_RUNNING;
		end
	end

endmodule

>>> hw/rtl/brace_config_lexer_checker.sv
// Top level of the brace config lexer checker: input, state and result registers.
//
// Channel text carries one beat per text byte (char_code) or an end marker
// (is_end). Channel token returns exactly one beat per text beat: the byte
// echoed, its role, word start/done and new-statement flags, the nesting
// depth after the byte, and a status (running, accepted, error).
// An end beat reports accept or error for the whole text and rearms the
// lexer, so the next byte starts a fresh text.
// Throughput: one beat per cycle while token is not stalled; the lexer
// state update is a single combinational step between the input and result registers.
// Stall on token holds the result register; text_stall rises only when
// both the input and the result register are full and token is stalled.
// Reset clears the lexer to between-tokens, start of text, depth zero,
// no error, and empties both registers.
// MAX_DEPTH sets the deepest brace nesting allowed (1 to 31).
module brace_config_lexer_checker #(
	parameter int MAX_DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  text_valid,
	output logic                  text_stall,
	input  bclx_pkg::text_item_t  text,
	output logic                  token_valid,
	input  logic                  token_stall,
	output bclx_pkg::token_item_t token
);
	import bclx_pkg::*;

	localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

	logic                valid_s1;
	text_item_t          item_s1;
	logic                valid_s2;
	token_item_t         res_s2;
	lex_mode_t           mode_q;
	tok_kind_t           kind_q;
	logic [DEPTH_W-1:0]  depth_q;
	logic                err_q;

	lex_mode_t           nxt_mode;
	tok_kind_t           nxt_kind;
	logic [DEPTH_W-1:0]  nxt_depth;
	logic                nxt_err;
	token_item_t         res;
	logic                adv;
	logic                take;

	assign adv        = valid_s1 && (!valid_s2 || !token_stall);
	assign text_stall = valid_s1 && !adv;
	assign take       = text_valid && !text_stall;

	bclx_step #(
		.MAX_DEPTH (MAX_DEPTH),
		.DEPTH_W   (DEPTH_W)
	) u_step (
		.item      (item_s1),
		.mode      (mode_q),
		.kind      (kind_q),
		.depth     (depth_q),
		.err       (err_q),
		.nxt_mode  (nxt_mode),
		.nxt_kind  (nxt_kind),
		.nxt_depth (nxt_depth),
		.nxt_err   (nxt_err),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) item_s1 <= text;
	end

	// advance lexer state once per consumed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_WS;
			kind_q  <= KIND_START;
			depth_q <= '0;
			err_q   <= 1'b0;
		end else if (adv) begin
			mode_q  <= nxt_mode;
			kind_q  <= nxt_kind;
			depth_q <= nxt_depth;
			err_q   <= nxt_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!token_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) res_s2 <= res;
	end

	assign token_valid = valid_s2;
	assign token       = res_s2;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(MAX_DEPTH))
		else $error("nesting depth above limit");

	a_end_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.is_end |=> mode_q == MODE_WS && kind_q == KIND_START &&
			depth_q == '0 && !err_q)
		else $error("end beat did not rearm lexer");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q && !(adv && item_s1.is_end) |=> err_q)
		else $error("error flag dropped before end beat");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		text_stall |-> valid_s2 && token_stall)
		else $error("input stalled without a blocked result");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && token_stall |=> valid_s2 && $stable(res_s2))
		else $error("stalled result changed");

endmodule

>>> test/brace_config_lexer_checker_tb.sv
// Testbench for the brace config lexer checker: directed table, random texts, token scoreboard.
module brace_config_lexer_checker_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bclx_pkg::*;

	localparam int NEST_LIMIT  = 16;
	localparam int ITEM_GOAL   = 1750;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 10;

	typedef struct {
		text_item_t  beat;
		int          reps;
		bit          pinned;
		token_item_t want;
	} text_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        text_valid = 1'b0;
	logic        text_stall;
	text_item_t  text = '0;
	logic        token_valid;
	logic        token_stall = 1'b0;
	token_item_t token;

	// lexer state as the checker sees it
	lex_mode_t   lex_mode;
	tok_kind_t   last_kind;
	logic [4:0]  nest_level;
	logic        text_bad;

	token_item_t pending_tokens[$];
	text_row_t   opening_rows[$];
	logic [7:0]  text_buf[$];
	int          sent_count = 0;
	int          fail_count = 0;
	int          cycle_count = 0;
	bit          tx_idle_on = 1'b1;
	bit          rx_idle_on = 1'b1;
	bit          long_hold_req = 1'b0;

	brace_config_lexer_checker #(
		.MAX_DEPTH(NEST_LIMIT)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text       (text),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.token      (token)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit ends_word(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
			c == CH_SEMI || c == CH_LBRACE || c == CH_RBRACE;
	endfunction

	function automatic void rearm_lexer();
		lex_mode = MODE_WS;
		last_kind = KIND_START;
		nest_level = '0;
		text_bad = 1'b0;
	endfunction

	// Classify a byte that arrives between tokens.
	task automatic classify_free(input logic [7:0] c, inout token_item_t tok);
		case (c)
		CH_LBRACE: begin
			tok.char_role = ROLE_OPEN;
			if (last_kind != KIND_NORMAL) text_bad = 1'b1;
			if (nest_level >= NEST_LIMIT) text_bad = 1'b1;
			else nest_level = nest_level + 1'b1;
			last_kind = KIND_OPEN;
		end
		CH_RBRACE: begin
			tok.char_role = ROLE_CLOSE;
			if (last_kind != KIND_OPEN && last_kind != KIND_END && last_kind != KIND_CLOSE)
				text_bad = 1'b1;
			if (nest_level == 0) text_bad = 1'b1;
			else nest_level = nest_level - 1'b1;
			last_kind = KIND_CLOSE;
		end
		CH_SEMI: begin
			tok.char_role = ROLE_STMT;
			if (last_kind != KIND_NORMAL) text_bad = 1'b1;
			last_kind = KIND_END;
		end
		CH_HASH: begin
			tok.char_role = ROLE_COMMENT;
			lex_mode = MODE_COMMENT;
		end
		CH_SPACE, CH_TAB, CH_LF, CH_CR: begin
			tok.char_role = ROLE_DROP;
		end
		default: begin
			tok.char_role = ROLE_TEXT;
			tok.word_start = 1'b1;
			tok.new_statement = (last_kind != KIND_NORMAL);
			last_kind = KIND_NORMAL;
			if (c == CH_DQUOTE) lex_mode = MODE_DQ;
			else if (c == CH_SQUOTE) lex_mode = MODE_SQ;
			else lex_mode = MODE_WORD;
		end
		endcase
	endtask

	task automatic predict_token(input text_item_t beat, output token_item_t tok);
		logic [7:0] c;
		logic       bad;
		c = beat.char_code;
		tok = '0;
		if (beat.is_end) begin
			bad = text_bad || (lex_mode != MODE_WS && lex_mode != MODE_COMMENT) ||
				(last_kind != KIND_START && last_kind != KIND_END && last_kind != KIND_CLOSE) ||
				nest_level != 0;
			tok.nest_depth = nest_level;
			tok.status = bad ? ST_ERROR : ST_ACCEPT;
			rearm_lexer();
		end else begin
			tok.byte_out = c;
			case (lex_mode)
			MODE_WS: begin
				classify_free(c, tok);
			end
			MODE_WORD: begin
				if (ends_word(c)) begin
					tok.word_done = 1'b1;
					lex_mode = MODE_WS;
					classify_free(c, tok);
				end else begin
					tok.char_role = ROLE_TEXT;
				end
			end
			MODE_DQ, MODE_SQ: begin
				if ((lex_mode == MODE_DQ && c == CH_DQUOTE) ||
					(lex_mode == MODE_SQ && c == CH_SQUOTE)) begin
					tok.char_role = ROLE_TEXT;
					lex_mode = MODE_AFTERQ;
				end else if (c == CH_BSLASH) begin
					tok.char_role = ROLE_DROP;
					if (lex_mode == MODE_DQ) lex_mode = MODE_DQ_ESC;
					else lex_mode = MODE_SQ_ESC;
				end else begin
					tok.char_role = ROLE_TEXT;
				end
			end
			MODE_DQ_ESC: begin
				tok.char_role = ROLE_TEXT;
				lex_mode = MODE_DQ;
			end
			MODE_SQ_ESC: begin
				tok.char_role = ROLE_TEXT;
				lex_mode = MODE_SQ;
			end
			MODE_COMMENT: begin
				if (c == CH_LF || c == CH_CR) begin
					tok.char_role = ROLE_DROP;
					lex_mode = MODE_WS;
				end else begin
					tok.char_role = ROLE_COMMENT;
				end
			end
			MODE_AFTERQ: begin
				// the closing quote must be followed by a delimiter
				tok.word_done = 1'b1;
				if (!ends_word(c)) text_bad = 1'b1;
				lex_mode = MODE_WS;
				classify_free(c, tok);
			end
			endcase
			tok.nest_depth = nest_level;
			tok.status = text_bad ? ST_ERROR : ST_RUNNING;
		end
	endtask

	function automatic void add_plain(input logic [7:0] c, input logic e, input int reps);
		text_row_t row;
		row.beat.char_code = c;
		row.beat.is_end = e;
		row.reps = reps;
		row.pinned = 1'b0;
		row.want = '0;
		opening_rows = {opening_rows, row};
	endfunction

	function automatic void add_pinned(input logic [7:0] c, input logic e,
		input logic [2:0] role, input logic ws, input logic wd, input logic ns,
		input logic [4:0] d, input logic [1:0] st);
		text_row_t row;
		row.beat.char_code = c;
		row.beat.is_end = e;
		row.reps = 1;
		row.pinned = 1'b1;
		row.want.byte_out = e ? 8'h00 : c;
		row.want.char_role = role;
		row.want.word_start = ws;
		row.want.word_done = wd;
		row.want.new_statement = ns;
		row.want.nest_depth = d;
		row.want.status = st;
		opening_rows = {opening_rows, row};
	endfunction

	// Offer one beat, wait for it to be taken, then record what it should produce.
	task automatic push_beat(input text_item_t beat, input bit pinned, input token_item_t want);
		token_item_t tok;
		if (tx_idle_on && $urandom_range(0, 5) == 0) begin
			text_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		text <= beat;
		text_valid <= 1'b1;
		do @(posedge clk); while (text_stall);
		predict_token(beat, tok);
		pending_tokens = {pending_tokens, pinned ? want : tok};
		sent_count++;
	endtask

	task automatic drain_tokens();
		text_valid <= 1'b0;
		while (pending_tokens.size() != 0) @(posedge clk);
	endtask

	function automatic void buf_add(input logic [7:0] c);
		text_buf = {text_buf, c};
	endfunction

	function automatic logic [7:0] word_byte();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (ends_word(c));
		return c;
	endfunction

	function automatic void put_space();
		logic [7:0] c;
		repeat ($urandom_range(1, 2)) begin
			case ($urandom_range(0, 3))
			0: buf_add(CH_SPACE);
			1: buf_add(CH_TAB);
			2: buf_add(CH_LF);
			default: buf_add(CH_CR);
			endcase
		end
		if ($urandom_range(0, 7) == 0) begin
			buf_add(CH_HASH);
			repeat ($urandom_range(0, 6)) begin
				do c = 8'($urandom_range(0, 255)); while (c == CH_LF || c == CH_CR);
				buf_add(c);
			end
			buf_add($urandom_range(0, 1) ? CH_LF : CH_CR);
		end
	endfunction

	function automatic void put_word();
		logic [7:0] q;
		logic [7:0] c;
		int         n;
		n = $urandom_range(0, 5);
		if ($urandom_range(0, 3) == 0) begin
			q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
			buf_add(q);
			repeat (n) begin
				if ($urandom_range(0, 3) == 0) begin
					buf_add(CH_BSLASH);
					buf_add(8'($urandom_range(0, 255)));
				end else begin
					do c = 8'($urandom_range(0, 255)); while (c == q || c == CH_BSLASH);
					buf_add(c);
				end
			end
			buf_add(q);
		end else begin
			do c = word_byte(); while (c == CH_HASH || c == CH_DQUOTE || c == CH_SQUOTE);
			buf_add(c);
			repeat (n) buf_add(word_byte());
		end
	endfunction

	// Build a well-formed text; a deep one starts with a long chain of opened blocks, which can pass the nesting limit.
	function automatic void build_clean(input bit deep);
		int open_n;
		open_n = 0;
		text_buf.delete();
		if (deep) begin
			repeat ($urandom_range(12, NEST_LIMIT + 1)) begin
				put_word();
				buf_add(CH_LBRACE);
				open_n++;
			end
		end
		repeat ($urandom_range(1, 8)) begin
			if ($urandom_range(0, 1)) put_space();
			if (open_n > 0 && $urandom_range(0, 3) == 0) begin
				buf_add(CH_RBRACE);
				open_n--;
			end else if (open_n < 3 && $urandom_range(0, 2) == 0) begin
				put_word();
				if ($urandom_range(0, 1)) put_space();
				buf_add(CH_LBRACE);
				open_n++;
			end else begin
				put_word();
				repeat ($urandom_range(0, 2)) begin
					put_space();
					put_word();
				end
				if ($urandom_range(0, 1)) put_space();
				buf_add(CH_SEMI);
			end
		end
		while (open_n > 0) begin
			if ($urandom_range(0, 2) == 0) put_space();
			buf_add(CH_RBRACE);
			open_n--;
		end
		if ($urandom_range(0, 1)) put_space();
	endfunction

	function automatic void spoil_text();
		int k;
		k = $urandom_range(0, text_buf.size() - 1);
		case ($urandom_range(0, 2))
		0: text_buf[k] = 8'($urandom_range(0, 255));
		1: while (text_buf.size() > k) text_buf.delete(text_buf.size() - 1);
		default: begin
			case ($urandom_range(0, 3))
			0: text_buf.insert(k, CH_LBRACE);
			1: text_buf.insert(k, CH_RBRACE);
			2: text_buf.insert(k, CH_SEMI);
			default: text_buf.insert(k, CH_DQUOTE);
			endcase
		end
		endcase
	endfunction

	task automatic check_field(input string name, input logic [7:0] exp_v,
		input logic [7:0] got_v);
		if (got_v !== exp_v) begin
			$error("token.%s: expected %0d, got %0d", name, exp_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : token_check
		token_item_t want;
		if (arst_n && token_valid && !token_stall) begin
			if (pending_tokens.size() == 0) begin
				$error("token: beat with nothing expected, byte_out %0d", token.byte_out);
				fail_count++;
			end else begin
				want = pending_tokens.pop_front();
				check_field("byte_out", want.byte_out, token.byte_out);
				check_field("char_role", want.char_role, token.char_role);
				check_field("word_start", want.word_start, token.word_start);
				check_field("word_done", want.word_done, token.word_done);
				check_field("new_statement", want.new_statement, token.new_statement);
				check_field("nest_depth", want.nest_depth, token.nest_depth);
				check_field("status", want.status, token.status);
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold-off on request.
	initial begin : token_sink
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				token_stall <= 1'b1;
				repeat (300) @(posedge clk);
				token_stall <= 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
				token_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				token_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		text_item_t  beat;
		token_item_t none;
		int          pick;
		bit          held;
		bit          paused;
		none = '0;
		held = 1'b0;
		paused = 1'b0;
		rearm_lexer();

		// accepted text: extremes, both quote kinds with escapes, a comment
		add_pinned(8'h00, 1'b0, ROLE_TEXT, 1'b1, 1'b0, 1'b1, 5'd0, ST_RUNNING);
		add_pinned(8'hFF, 1'b0, ROLE_TEXT, 1'b0, 1'b0, 1'b0, 5'd0, ST_RUNNING);
		add_pinned(CH_TAB, 1'b0, ROLE_DROP, 1'b0, 1'b1, 1'b0, 5'd0, ST_RUNNING);
		add_pinned(CH_LBRACE, 1'b0, ROLE_OPEN, 1'b0, 1'b0, 1'b0, 5'd1, ST_RUNNING);
		add_plain(CH_DQUOTE, 1'b0, 1);
		add_plain(CH_BSLASH, 1'b0, 1);
		add_plain(CH_DQUOTE, 1'b0, 1);
		add_plain(CH_DQUOTE, 1'b0, 1);
		add_plain(CH_SEMI, 1'b0, 1);
		add_plain(CH_HASH, 1'b0, 1);
		add_plain(8'h78, 1'b0, 1);
		add_plain(CH_CR, 1'b0, 1);
		add_plain(CH_SQUOTE, 1'b0, 1);
		add_plain(CH_BSLASH, 1'b0, 1);
		add_plain(CH_SQUOTE, 1'b0, 1);
		add_plain(CH_SQUOTE, 1'b0, 1);
		add_plain(CH_SEMI, 1'b0, 1);
		add_plain(CH_RBRACE, 1'b0, 1);
		add_pinned(8'hA5, 1'b1, ROLE_DROP, 1'b0, 1'b0, 1'b0, 5'd0, ST_ACCEPT);
		// non-delimiter right after a closing quote, then end inside a word
		add_plain(CH_DQUOTE, 1'b0, 1);
		add_plain(CH_DQUOTE, 1'b0, 1);
		add_plain(8'h7A, 1'b0, 1);
		add_pinned(8'h00, 1'b1, ROLE_DROP, 1'b0, 1'b0, 1'b0, 5'd0, ST_ERROR);
		// close at depth zero, statement end with no word
		add_pinned(CH_RBRACE, 1'b0, ROLE_CLOSE, 1'b0, 1'b0, 1'b0, 5'd0, ST_ERROR);
		add_pinned(8'h00, 1'b1, ROLE_DROP, 1'b0, 1'b0, 1'b0, 5'd0, ST_ERROR);
		add_pinned(CH_SEMI, 1'b0, ROLE_STMT, 1'b0, 1'b0, 1'b0, 5'd0, ST_ERROR);
		add_pinned(8'h00, 1'b1, ROLE_DROP, 1'b0, 1'b0, 1'b0, 5'd0, ST_ERROR);
		// one open past the nesting limit; the depth holds at the limit
		add_plain(CH_LBRACE, 1'b0, NEST_LIMIT + 1);
		add_pinned(8'hFF, 1'b1, ROLE_DROP, 1'b0, 1'b0, 1'b0, 5'(NEST_LIMIT), ST_ERROR);
		// empty text
		add_pinned(8'h00, 1'b1, ROLE_DROP, 1'b0, 1'b0, 1'b0, 5'd0, ST_ACCEPT);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (opening_rows[i]) begin
			repeat (opening_rows[i].reps)
				push_beat(opening_rows[i].beat, opening_rows[i].pinned, opening_rows[i].want);
		end

		while (sent_count < ITEM_GOAL) begin
			pick = $urandom_range(0, 19);
			build_clean(pick == 0);
			if (pick >= 14 && pick <= 17) begin
				spoil_text();
			end else if (pick >= 18) begin
				text_buf.delete();
				repeat ($urandom_range(1, 30)) buf_add(8'($urandom_range(0, 255)));
			end
			if (sent_count > ITEM_GOAL - 250) begin
				tx_idle_on = 1'b0;
				rx_idle_on = 1'b0;
			end else begin
				tx_idle_on = $urandom_range(0, 2) != 0;
				rx_idle_on = $urandom_range(0, 2) != 0;
			end
			if (!held && sent_count > 600) begin
				held = 1'b1;
				long_hold_req = 1'b1;
			end
			if (!paused && sent_count > 1100) begin
				paused = 1'b1;
				drain_tokens();
			end
			foreach (text_buf[i]) begin
				beat.char_code = text_buf[i];
				beat.is_end = 1'b0;
				push_beat(beat, 1'b0, none);
			end
			beat.char_code = 8'($urandom_range(0, 255));
			beat.is_end = 1'b1;
			push_beat(beat, 1'b0, none);
		end

		drain_tokens();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
